/* rtl/bbe_pkg.sv */
package bbe_pkg;

	// Frame geometry limits.
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int EFF_W     = $clog2(MAX_WIDTH + 1);
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 16;
	localparam int ROW_W     = HEIGHT_W + 1;

	// Pixel layout: red in the top byte, blue in the bottom byte.
	localparam int CHAN_W  = 8;
	localparam int NUM_CH  = 3;
	localparam int PIXEL_W = NUM_CH * CHAN_W;

	// Configuration port.
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int REG_SEL_BIT = 2;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	// Queue between the window side and the arithmetic side.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Arithmetic widths.
	localparam int ROWSUM_W    = CHAN_W + 2;
	localparam int SUM_W       = CHAN_W + 4;
	localparam int X_W         = SUM_W + 1;
	localparam int N_W         = 4;
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = RECIP_SHIFT;
	localparam int PROD_W      = X_W + RECIP_W;

	// Rounded-up reciprocals of 2*n for each legal neighbor count n.
	localparam int RECIP_N1 = (2 ** RECIP_SHIFT + 1) / 2;
	localparam int RECIP_N2 = (2 ** RECIP_SHIFT + 3) / 4;
	localparam int RECIP_N3 = (2 ** RECIP_SHIFT + 5) / 6;
	localparam int RECIP_N4 = (2 ** RECIP_SHIFT + 7) / 8;
	localparam int RECIP_N6 = (2 ** RECIP_SHIFT + 11) / 12;
	localparam int RECIP_N9 = (2 ** RECIP_SHIFT + 17) / 18;

	typedef logic [PIXEL_W-1:0] pixel_t;

	// One output pixel's worth of work: the 3x3 window and which taps are inside the image.
	typedef struct packed {
		pixel_t [2:0][2:0] win;
		logic [2:0]        row_ok;
		logic [2:0]        col_ok;
		logic              frame_end;
	} blur_job_t;

	// Effective frame geometry handed from the register block to the front end.
	typedef struct packed {
		logic [EFF_W-1:0]    width;
		logic [HEIGHT_W-1:0] height;
		logic                restart;
	} frame_cfg_t;

	// Width register value clamped to the supported range.
	function automatic logic [EFF_W-1:0] eff_width(input logic [WIDTH_W-1:0] raw);
		logic [EFF_W-1:0] w;
		if (raw == '0) begin
			w = EFF_W'(1);
		end else if (int'(raw) > MAX_WIDTH) begin
			w = EFF_W'(MAX_WIDTH);
		end else begin
			w = EFF_W'(raw);
		end
		return w;
	endfunction

	// Number of set bits in a three-bit mask.
	function automatic logic [1:0] count3(input logic [2:0] m);
		return {1'b0, m[0]} + {1'b0, m[1]} + {1'b0, m[2]};
	endfunction

	// Reciprocal of 2*n, scaled by 2**RECIP_SHIFT.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [N_W-1:0] n);
		logic [RECIP_W-1:0] m;
		unique case (n)
			N_W'(1): m = RECIP_W'(RECIP_N1);
			N_W'(2): m = RECIP_W'(RECIP_N2);
			N_W'(3): m = RECIP_W'(RECIP_N3);
			N_W'(4): m = RECIP_W'(RECIP_N4);
			N_W'(6): m = RECIP_W'(RECIP_N6);
			N_W'(9): m = RECIP_W'(RECIP_N9);
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

/* rtl/bbe_ram.sv */
module bbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/bbe_front.sv */
module bbe_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bbe_pkg::frame_cfg_t         cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bbe_pkg::CHAN_W-1:0]  red_in,
	input  logic [bbe_pkg::CHAN_W-1:0]  green_in,
	input  logic [bbe_pkg::CHAN_W-1:0]  blue_in,
	input  logic                        drain,
	output logic                        enq_valid,
	input  logic                        enq_ready,
	output bbe_pkg::blur_job_t          enq_job
);
	import bbe_pkg::*;

	// Input position in the frame.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Item waiting for its line store data.
	logic                   valid_s1;
	logic [COL_W-1:0]       addr_s1;
	pixel_t                 pix_s1;
	logic                   emit_s1;
	logic [2:0]             row_ok_s1;
	logic [2:0]             col_ok_s1;
	logic                   frame_end_s1;
	logic                   fwd_s1;
	logic [2*PIXEL_W-1:0]   fwd_data_s1;

	pixel_t [2:0][2:0] window_q;
	pixel_t [2:0][2:0] win_next;
	pixel_t [2:0]      new_col;

	logic [ROW_W-1:0]     h_ext;
	logic                 accept;
	logic                 flushing;
	logic                 take;
	logic                 case_a;
	logic                 case_b;
	logic                 emit;
	logic                 frame_end;
	logic [2:0]           row_ok;
	logic [2:0]           col_ok;
	logic                 wrap;
	pixel_t               pix;
	pixel_t               top_eff;
	pixel_t               mid_eff;
	logic [2*PIXEL_W-1:0] ram_rdata;
	logic [2*PIXEL_W-1:0] ram_wdata;
	logic                 s1_go;

	// Classify the incoming item from the current position.
	assign h_ext    = ROW_W'(cfg.height);
	assign accept   = in_valid && in_ready;
	assign flushing = row_q >= h_ext;
	assign take     = accept && !(drain && !flushing);
	assign case_a   = (col_q != '0) && (row_q >= ROW_W'(1));
	assign case_b   = (col_q == '0) && (row_q >= ROW_W'(2));
	assign emit     = case_a || case_b;
	assign pix      = flushing ? '0 : {red_in, green_in, blue_in};
	assign wrap     = (EFF_W'(col_q) + EFF_W'(1)) >= cfg.width;

	// Which window taps fall inside the image for the pixel about to be finished.
	always_comb begin
		if (case_b) begin
			row_ok    = {row_q <= h_ext, 1'b1, row_q >= ROW_W'(3)};
			col_ok    = {1'b0, 1'b1, cfg.width > EFF_W'(1)};
			frame_end = row_q == (h_ext + ROW_W'(1));
		end else begin
			row_ok    = {row_q < h_ext, 1'b1, row_q >= ROW_W'(2)};
			col_ok    = {1'b1, 1'b1, col_q >= COL_W'(2)};
			frame_end = 1'b0;
		end
	end

	// Position counters; a configuration write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (emit && frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// The stage moves on once its result, if any, has a place in the queue.
	assign s1_go    = valid_s1 && (!emit_s1 || enq_ready);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// A read of the column being written in the same cycle takes the new data.
	always_ff @(posedge clk) begin
		if (take) begin
			addr_s1      <= col_q;
			pix_s1       <= pix;
			emit_s1      <= emit;
			row_ok_s1    <= row_ok;
			col_ok_s1    <= col_ok;
			frame_end_s1 <= frame_end;
			fwd_s1       <= s1_go && (addr_s1 == col_q);
			fwd_data_s1  <= ram_wdata;
		end
	end

	// Line stores: upper line in the top half, middle line in the bottom half.
	assign {top_eff, mid_eff} = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign ram_wdata          = {mid_eff, pix_s1};

	bbe_ram #(
		.WIDTH(2 * PIXEL_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_go),
		.waddr(addr_s1),
		.wdata(ram_wdata),
		.re   (take),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// Shift the window left by one column and bring in the new column.
	always_comb begin
		new_col[0] = top_eff;
		new_col[1] = mid_eff;
		new_col[2] = pix_s1;
		for (int i = 0; i < 3; i++) begin
			win_next[i][0] = window_q[i][1];
			win_next[i][1] = window_q[i][2];
			win_next[i][2] = new_col[i];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			window_q <= win_next;
		end
	end

	// Hand a finished window to the arithmetic side.
	assign enq_valid         = valid_s1 && emit_s1;
	assign enq_job.win       = win_next;
	assign enq_job.row_ok    = row_ok_s1;
	assign enq_job.col_ok    = col_ok_s1;
	assign enq_job.frame_end = frame_end_s1;

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		EFF_W'(col_q) < cfg.width)
		else $error("column position beyond the frame width");

	a_row_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= (h_ext + ROW_W'(1)))
		else $error("row position beyond the flush rows");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit && frame_end |=> (col_q == '0) && (row_q == '0))
		else $error("position not cleared after the last pixel of the frame");

endmodule

/* rtl/bbe_queue.sv */
module bbe_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               enq_valid,
	output logic               enq_ready,
	input  bbe_pkg::blur_job_t enq_job,
	output logic               deq_valid,
	input  logic               deq_ready,
	output bbe_pkg::blur_job_t deq_job
);
	import bbe_pkg::*;

	blur_job_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop;

	function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
		return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
	endfunction

	assign enq_ready = count_q != QUEUE_CNT_W'(QUEUE_DEPTH);
	assign deq_valid = count_q != '0;
	assign deq_job   = slot_q[rd_ptr_q];
	assign push      = enq_valid && enq_ready;
	assign pop       = deq_valid && deq_ready;

	// Storage for queued windows.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= enq_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QUEUE_CNT_W'(1);
				2'b01:   count_q <= count_q - QUEUE_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("queue fill level beyond its depth");

endmodule

/* rtl/bbe_back.sv */
module bbe_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	output logic                       job_ready,
	input  bbe_pkg::blur_job_t         job,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bbe_pkg::CHAN_W-1:0] red_out,
	output logic [bbe_pkg::CHAN_W-1:0] green_out,
	output logic [bbe_pkg::CHAN_W-1:0] blue_out,
	output logic                       frame_end
);
	import bbe_pkg::*;

	logic [ROWSUM_W-1:0] rowsum_d  [NUM_CH][3];
	logic [ROWSUM_W-1:0] rowsum_s1 [NUM_CH][3];
	logic [N_W-1:0]      n_s1;
	logic                fe_s1;
	logic                valid_s1;

	logic [X_W-1:0]      x_s2 [NUM_CH];
	logic [RECIP_W-1:0]  m_s2;
	logic                fe_s2;
	logic                valid_s2;

	logic [PROD_W-1:0]   prod_s3 [NUM_CH];
	logic                fe_s3;
	logic                valid_s3;

	logic [CHAN_W-1:0]   avg_q [NUM_CH];
	logic                fe_q;
	logic                out_valid_q;

	logic                free1;
	logic                free2;
	logic                free3;
	logic                free_out;

	// A stage loads when it is empty or its contents move on.
	assign free_out  = !out_valid_q || out_ready;
	assign free3     = !valid_s3 || free_out;
	assign free2     = !valid_s2 || free3;
	assign free1     = !valid_s1 || free2;
	assign job_ready = free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free1) begin
				valid_s1 <= job_valid;
			end
			if (free2) begin
				valid_s2 <= valid_s1;
			end
			if (free3) begin
				valid_s3 <= valid_s2;
			end
			if (free_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	// Per-row sums of the taps that lie inside the image, one lane per channel.
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int i = 0; i < 3; i++) begin
				rowsum_d[ch][i] = '0;
				for (int j = 0; j < 3; j++) begin
					if (job.row_ok[i] && job.col_ok[j]) begin
						rowsum_d[ch][i] = rowsum_d[ch][i] +
							ROWSUM_W'(job.win[i][j][CHAN_W*(NUM_CH-1-ch) +: CHAN_W]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free1) begin
			rowsum_s1 <= rowsum_d;
			n_s1      <= N_W'(count3(job.row_ok)) * N_W'(count3(job.col_ok));
			fe_s1     <= job.frame_end;
		end
	end

	// Numerator 2*sum + n and the reciprocal of 2*n.
	always_ff @(posedge clk) begin
		if (free2) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				x_s2[ch] <= {SUM_W'(rowsum_s1[ch][0]) + SUM_W'(rowsum_s1[ch][1]) +
					SUM_W'(rowsum_s1[ch][2]), 1'b0} + X_W'(n_s1);
			end
			m_s2  <= recip_of(n_s1);
			fe_s2 <= fe_s1;
		end
	end

	// Division by 2*n as a multiplication by its reciprocal.
	always_ff @(posedge clk) begin
		if (free3) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				prod_s3[ch] <= PROD_W'(x_s2[ch]) * PROD_W'(m_s2);
			end
			fe_s3 <= fe_s2;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (free_out) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				avg_q[ch] <= prod_s3[ch][RECIP_SHIFT +: CHAN_W];
			end
			fe_q <= fe_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = avg_q[0];
	assign green_out = avg_q[1];
	assign blue_out  = avg_q[2];
	assign frame_end = fe_q;

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (n_s1 == N_W'(1)) || (n_s1 == N_W'(2)) || (n_s1 == N_W'(3)) ||
			(n_s1 == N_W'(4)) || (n_s1 == N_W'(6)) || (n_s1 == N_W'(9)))
		else $error("neighbor count not a product of row and column counts");

endmodule

/* rtl/box_blur_3x3_edge_aware.sv */
// 3x3 box blur over a raster-order RGB stream, averaging only the neighbors
// that lie inside the frame (4 at a corner, 6 on an edge, 9 inside, fewer in
// frames one pixel wide or tall), rounded half up.
// Input channel: in_valid/in_ready with red_in, green_in, blue_in and drain.
// Output channel: out_valid/out_ready with red_out, green_out, blue_out and
// frame_end, which marks the last pixel of the frame.
// Results trail the stream by one row plus one pixel; after the last pixel of
// a frame, image_width + 1 more transfers (drain set, or any data) flush it.
// A drain transfer in the middle of a frame is taken and ignored.
// Throughput is one transfer per clock while out_ready stays high. After the
// transfer that completes its neighborhood, a result passes the line store
// read, the queue, the sum, reciprocal and multiply stages, and then leaves
// the output register.
// Registers over the APB port: image_width at 0x0, image_height at 0x4; write
// them only while the block is idle. A write restarts the frame position.
// Reset clears position and pipeline and loads 640 x 480; line store contents
// are not cleared, since rows outside the frame are never summed.
// When out_ready is low, results collect in the pipeline and a two-entry
// queue; in_ready drops once these are full.
module box_blur_3x3_edge_aware (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bbe_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bbe_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bbe_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bbe_pkg::CHAN_W-1:0]     red_in,
	input  logic [bbe_pkg::CHAN_W-1:0]     green_in,
	input  logic [bbe_pkg::CHAN_W-1:0]     blue_in,
	input  logic                           drain,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bbe_pkg::CHAN_W-1:0]     red_out,
	output logic [bbe_pkg::CHAN_W-1:0]     green_out,
	output logic [bbe_pkg::CHAN_W-1:0]     blue_out,
	output logic                           frame_end
);
	import bbe_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                cfg_write;
	reg_index_t          reg_sel;
	frame_cfg_t          frame_cfg;
	logic                enq_valid;
	logic                enq_ready;
	blur_job_t           enq_job;
	logic                deq_valid;
	logic                deq_ready;
	blur_job_t           deq_job;

	// Register file: a transfer completes in the access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel   = reg_index_t'(paddr[REG_SEL_BIT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(WIDTH_RESET);
			height_q <= HEIGHT_W'(HEIGHT_RESET);
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
				default:          width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	// Effective geometry: zero values become one and an oversized width is clamped.
	assign frame_cfg.width   = eff_width(width_q);
	assign frame_cfg.height  = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	assign frame_cfg.restart = cfg_write;

	bbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (frame_cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.drain    (drain),
		.enq_valid(enq_valid),
		.enq_ready(enq_ready),
		.enq_job  (enq_job)
	);

	bbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq_valid(enq_valid),
		.enq_ready(enq_ready),
		.enq_job  (enq_job),
		.deq_valid(deq_valid),
		.deq_ready(deq_ready),
		.deq_job  (deq_job)
	);

	bbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(deq_valid),
		.job_ready(deq_ready),
		.job      (deq_job),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red_out  (red_out),
		.green_out(green_out),
		.blue_out (blue_out),
		.frame_end(frame_end)
	);

endmodule

/* tb/blur_checker.sv */
`timescale 1ns / 100ps

// Watches the configuration port and both pixel channels of the blur block.
// It keeps its own copy of the line stores, the window and the frame position,
// predicts every blurred pixel, and compares each output transfer with the
// oldest prediction.
module blur_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bbe_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bbe_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [bbe_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [bbe_pkg::CHAN_W-1:0]     red_in,
	input  logic [bbe_pkg::CHAN_W-1:0]     green_in,
	input  logic [bbe_pkg::CHAN_W-1:0]     blue_in,
	input  logic                           drain,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [bbe_pkg::CHAN_W-1:0]     red_out,
	input  logic [bbe_pkg::CHAN_W-1:0]     green_out,
	input  logic [bbe_pkg::CHAN_W-1:0]     blue_out,
	input  logic                           frame_end,
	output int                             mismatches,
	output int                             backlog
);
	import bbe_pkg::*;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last;
	} blurred_px_t;

	// Blurred pixels predicted but not yet seen on the output channel.
	blurred_px_t pending_pixels[$];

	// Shadow registers and the predicted datapath state.
	logic [WIDTH_W-1:0]  width_reg;
	logic [HEIGHT_W-1:0] height_reg;
	pixel_t              upper_mem [MAX_WIDTH];
	pixel_t              middle_mem [MAX_WIDTH];
	pixel_t              win [9];
	int unsigned         col_pos;
	int unsigned         row_pos;
	int unsigned         emitted;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Rounded-half-up mean of one channel over n taps.
	function automatic logic [CHAN_W-1:0] rounded_mean(input int unsigned sum,
			input int unsigned n);
		return CHAN_W'((2 * sum + n) / (2 * n));
	endfunction

	// Advance the window by one input transfer and queue the pixel it completes.
	task automatic predict_blur(input pixel_t rgb, input logic is_drain);
		int unsigned w, h, c, r, total, orow, ocol, n;
		int unsigned sum_r, sum_g, sum_b;
		int          i, j;
		pixel_t      top, mid, pix, tap;
		logic        flushing, emit, row_in, col_in;
		blurred_px_t px;
		w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		h = (height_reg == 0) ? 1 : height_reg;
		total = w * h;
		c = col_pos;
		r = row_pos;
		flushing = (r >= h);

		// A drain inside the frame moves nothing.
		if (is_drain && !flushing) return;
		if (c >= w) c = 0;
		pix = flushing ? '0 : rgb;

		top = upper_mem[c];
		mid = middle_mem[c];
		upper_mem[c] = mid;
		middle_mem[c] = pix;
		for (i = 0; i < 3; i++) begin
			win[i * 3]     = win[i * 3 + 1];
			win[i * 3 + 1] = win[i * 3 + 2];
			win[i * 3 + 2] = (i == 0) ? top : (i == 1) ? mid : pix;
		end

		// The window center trails the input by one row and one column.
		emit = 1'b0;
		orow = 0;
		ocol = 0;
		if (c >= 1 && r >= 1) begin
			orow = r - 1;
			ocol = c - 1;
			emit = 1'b1;
		end else if (c == 0 && r >= 2) begin
			orow = r - 2;
			ocol = w - 1;
			emit = 1'b1;
		end
		if (emit && emitted >= total) emit = 1'b0;

		if (emit) begin
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			n = 0;
			for (i = 0; i < 3; i++) begin
				row_in = (i == 0) ? (orow > 0) : (i == 2) ? (orow + 1 < h) : 1'b1;
				for (j = 0; j < 3; j++) begin
					col_in = (j == 0) ? (ocol > 0) : (j == 2) ? (ocol + 1 < w) : 1'b1;
					if (row_in && col_in) begin
						tap = win[i * 3 + j];
						sum_r += tap[2 * CHAN_W +: CHAN_W];
						sum_g += tap[CHAN_W +: CHAN_W];
						sum_b += tap[0 +: CHAN_W];
						n++;
					end
				end
			end
			emitted++;
			px.red   = rounded_mean(sum_r, n);
			px.green = rounded_mean(sum_g, n);
			px.blue  = rounded_mean(sum_b, n);
			px.last  = (emitted == total);
			pending_pixels.push_back(px);
		end

		if (c + 1 >= w) begin
			c = 0;
			r++;
		end else begin
			c++;
		end
		col_pos = c;
		row_pos = r & 32'h1FFFF;

		// The last pixel of the frame sends the position back to the origin.
		if (emit && emitted == total) begin
			col_pos = 0;
			row_pos = 0;
			emitted = 0;
		end
	endtask

	// Sample all three ports at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		blurred_px_t      want;
		logic [APB_DATA_W-1:0] reg_val;
		if (!arst_n) begin
			width_reg = WIDTH_W'(WIDTH_RESET);
			height_reg = HEIGHT_W'(HEIGHT_RESET);
			for (int k = 0; k < MAX_WIDTH; k++) begin
				upper_mem[k] = '0;
				middle_mem[k] = '0;
			end
			for (int k = 0; k < 9; k++) win[k] = '0;
			col_pos = 0;
			row_pos = 0;
			emitted = 0;
			pending_pixels.delete();
			mismatches = 0;
			backlog <= 0;
		end else begin
			// Register access: a write restarts the frame, a read must match.
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (reg_index_t'(paddr[REG_SEL_BIT]) == REG_IMAGE_WIDTH) begin
						width_reg = pwdata[WIDTH_W-1:0];
					end else begin
						height_reg = pwdata[HEIGHT_W-1:0];
					end
					col_pos = 0;
					row_pos = 0;
					emitted = 0;
				end else begin
					if (reg_index_t'(paddr[REG_SEL_BIT]) == REG_IMAGE_WIDTH) begin
						reg_val = APB_DATA_W'(width_reg);
					end else begin
						reg_val = APB_DATA_W'(height_reg);
					end
					if (prdata !== reg_val) begin
						report_mismatch($sformatf("register read at 0x%0h: got 0x%0h, expected 0x%0h",
							paddr, prdata, reg_val));
					end
				end
			end

			// Output transfer against the oldest prediction.
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("output pixel %0h/%0h/%0h/%0b with nothing pending",
						red_out, green_out, blue_out, frame_end));
				end else begin
					want = pending_pixels.pop_front();
					if (red_out !== want.red)
						report_mismatch($sformatf("red_out got %0h, expected %0h",
							red_out, want.red));
					if (green_out !== want.green)
						report_mismatch($sformatf("green_out got %0h, expected %0h",
							green_out, want.green));
					if (blue_out !== want.blue)
						report_mismatch($sformatf("blue_out got %0h, expected %0h",
							blue_out, want.blue));
					if (frame_end !== want.last)
						report_mismatch($sformatf("frame_end got %0b, expected %0b",
							frame_end, want.last));
				end
			end

			// Input transfer drives the prediction.
			if (in_valid && in_ready) begin
				predict_blur({red_in, green_in, blue_in}, drain);
			end
			backlog <= pending_pixels.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the edge-aware box blur. The checker beside the
// block does all prediction and comparison.
module testbench;
	import bbe_pkg::*;

	localparam int RANDOM_ITEMS = 250;
	localparam int PIPE_SETTLE  = 16;
	localparam int STALL_LIMIT  = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	logic [CHAN_W-1:0]     red_in;
	logic [CHAN_W-1:0]     green_in;
	logic [CHAN_W-1:0]     blue_in;
	logic                  drain;
	logic                  out_valid;
	logic                  out_ready;
	logic [CHAN_W-1:0]     red_out;
	logic [CHAN_W-1:0]     green_out;
	logic [CHAN_W-1:0]     blue_out;
	logic                  frame_end;
	int                    mismatches;
	int                    backlog;

	// Current register contents and the geometry they give.
	int unsigned width_raw;
	int unsigned height_raw;
	int unsigned frame_w;
	int unsigned frame_h;
	int unsigned items_sent;
	bit          in_calm;

	box_blur_3x3_edge_aware u_dut (.*);
	blur_checker u_checker (.*);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One input transfer, preceded by a random gap.
	task automatic send_item(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b, input logic is_drain);
		int gap;
		gap = in_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		drain    <= is_drain;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Setup and access cycles of one register access.
	task automatic reg_access(input reg_index_t idx, input logic is_write,
			input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= APB_ADDR_W'(idx) << REG_SEL_BIT;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait until every predicted pixel has come out.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// Write width and/or height (junk above the field) and maybe read both back.
	task automatic program_frame(input int unsigned raw_w, input int unsigned raw_h,
			input int order);
		logic [APB_DATA_W-1:0] junk;
		junk = $urandom;
		if (order != 3) begin
			width_raw = raw_w;
			if (order == 1) reg_access(REG_IMAGE_HEIGHT, 1'b1,
				(junk & ~32'hFFFF) | raw_h);
			reg_access(REG_IMAGE_WIDTH, 1'b1, (junk & ~32'h7FF) | raw_w);
		end
		if (order != 2) begin
			height_raw = raw_h;
			if (order != 1) reg_access(REG_IMAGE_HEIGHT, 1'b1,
				(junk & ~32'hFFFF) | raw_h);
		end
		if (order == 1) height_raw = raw_h;
		if ($urandom_range(0, 2) == 0) begin
			reg_access(REG_IMAGE_WIDTH, 1'b0, '0);
			reg_access(REG_IMAGE_HEIGHT, 1'b0, '0);
		end
		frame_w = (width_raw == 0) ? 1 : (width_raw > MAX_WIDTH) ? MAX_WIDTH : width_raw;
		frame_h = (height_raw == 0) ? 1 : height_raw;
	endtask

	// A frame of random pixels followed by its flush, cut short after n_items.
	task automatic stream_frame(input int unsigned n_items);
		int unsigned k, area;
		area = frame_w * frame_h;
		for (k = 0; k < n_items; k++) begin
			if (k < area) begin
				if (!in_calm && $urandom_range(0, 9) == 0) begin
					send_item(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
						1'b1);
				end
				send_item(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), 1'b0);
			end else begin
				send_item(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
					1'($urandom_range(0, 1)));
			end
			items_sent++;
		end
	endtask

	// Output side: random stalls, with calm stretches in between.
	initial begin : out_pacing
		int  stall;
		int  stretch;
		bit  calm;
		out_ready = 1'b0;
		stall = 0;
		stretch = 0;
		calm = 1'b0;
		forever begin
			@(posedge clk);
			if (stretch == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				stretch = $urandom_range(50, 300);
			end
			stretch--;
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!calm) stall = pick_gap();
			end
		end
	end

	// Give up when no transfer of any kind happens for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		logic [CHAN_W-1:0] ramp [9];
		int unsigned       k, raw_w, raw_h, full_len, cut, start_count;
		int                roll, frames, f;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		red_in   = '0;
		green_in = '0;
		blue_in  = '0;
		drain    = 1'b0;
		in_calm  = 1'b0;
		items_sent = 0;
		width_raw  = WIDTH_RESET;
		height_raw = HEIGHT_RESET;
		ramp = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'hFE, 8'h80};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of both registers.
		reg_access(REG_IMAGE_WIDTH, 1'b0, '0);
		reg_access(REG_IMAGE_HEIGHT, 1'b0, '0);

		// 3x3 frame: corners, edges and center, with extreme channel values
		// and a drain in the middle of the frame that must be ignored.
		program_frame(3, 3, 0);
		for (k = 0; k < 9; k++) begin
			if (k == 4) send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
			send_item(ramp[k], ramp[8 - k], ~ramp[k], 1'b0);
		end
		send_item(8'h12, 8'h34, 8'h56, 1'b0);
		send_item(8'h00, 8'h00, 8'h00, 1'b1);
		send_item(8'hFF, 8'h00, 8'hFF, 1'b1);
		send_item(8'hA5, 8'h5A, 8'hC3, 1'b0);

		// Zero width and zero height act as a single-pixel frame.
		quiesce();
		program_frame(0, 0, 1);
		send_item(8'h00, 8'h00, 8'h00, 1'b1);
		send_item(8'hFF, 8'h7F, 8'h01, 1'b0);
		send_item(8'h00, 8'h00, 8'h00, 1'b1);
		send_item(8'h33, 8'h44, 8'h55, 1'b0);

		// One pixel wide column.
		quiesce();
		program_frame(1, 3, 0);
		send_item(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_item(8'h00, 8'h01, 8'h02, 1'b0);
		send_item(8'hFF, 8'h00, 8'h80, 1'b0);
		send_item(8'h00, 8'h00, 8'h00, 1'b1);
		send_item(8'h00, 8'h00, 8'h00, 1'b0);

		// Width above the limit clamps to the full line store; the tallest
		// frame is cut after the second row has started, then restarted.
		quiesce();
		program_frame(2047, 65535, 0);
		in_calm = ($urandom_range(0, 1) == 0);
		stream_frame(MAX_WIDTH + 24);

		// Random geometries, mostly small, with whole frames and a few cut short.
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			raw_w = (roll < 60) ? $urandom_range(1, 6) : (roll < 85) ? $urandom_range(7, 24) :
				(roll < 92) ? 0 : $urandom_range(25, 64);
			roll = $urandom_range(0, 99);
			raw_h = (roll < 60) ? $urandom_range(1, 5) : (roll < 80) ? $urandom_range(6, 12) :
				(roll < 88) ? 0 : (roll < 95) ? $urandom_range(13, 40) :
				$urandom_range(41, 65535);
			quiesce();
			program_frame(raw_w, raw_h, $urandom_range(0, 3));
			in_calm = ($urandom_range(0, 4) == 0);
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				full_len = frame_w * frame_h + frame_w + 1;
				cut = full_len;
				if (frame_w * frame_h > 240) begin
					cut = $urandom_range(frame_w + 2, frame_w + 240);
				end else if ($urandom_range(0, 6) == 0) begin
					cut = $urandom_range(0, full_len - 1);
				end
				stream_frame(cut);
				if (cut < full_len) break;
			end
		end

		quiesce();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
